### hdl/assert_macros.svh
// Assertion macros for the RTL. Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, prop)

`define ASSERT_NEVER(label, prop)

`endif

`endif

### hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic {
    ReqInsert  = 1'b0,
    ReqExtract = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StFull      = 2'd1,
    StExtracted = 2'd2,
    StEmpty     = 2'd3
  } status_e;

  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                   ins;
    logic                   ext;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/spq_cell.sv
`default_nettype none

module spq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire spq_pkg::cmd_t   cmd_i,
  input  wire spq_pkg::entry_t left_i,
  input  wire logic            left_gt_i,
  input  wire spq_pkg::entry_t right_i,
  output spq_pkg::entry_t      ent_o,
  output logic                 gt_o
);

  logic                            valid_q, valid_d;
  logic signed [spq_pkg::KeyW-1:0] key_q, key_d;
  logic signed [spq_pkg::ValW-1:0] value_q, value_d;

  // empty cells count as holding a key above any new key
  assign gt_o = !valid_q || (key_q > cmd_i.key);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (cmd_i.ins) begin
      if (gt_o) begin
        if (left_gt_i) begin
          valid_d = left_i.valid;
          key_d   = left_i.key;
          value_d = left_i.value;
        end else begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          value_d = cmd_i.value;
        end
      end
    end else if (cmd_i.ext) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign ent_o.valid = valid_q;
  assign ent_o.key   = key_q;
  assign ent_o.value = value_q;

endmodule

`default_nettype wire

### hdl/sorted_priority_queue.sv
// A result is registered and becomes valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; every cell shifts or holds in parallel.
// Input stalls only while the held result is itself stalled.
// Reset (rst_ni low, asynchronous) clears cell valid bits, the fill count
// and the result valid; stored keys and values need no reset.
`default_nettype none

`include "assert_macros.svh"

module sorted_priority_queue (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            req_type_i,
  input  wire logic signed [spq_pkg::KeyW-1:0] key_i,
  input  wire logic signed [spq_pkg::ValW-1:0] value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [spq_pkg::KeyW-1:0]      out_key_o,
  output logic signed [spq_pkg::ValW-1:0]      out_value_o,
  output logic [spq_pkg::CntW-1:0]             fill_count_o
);

  spq_pkg::entry_t                 ent   [spq_pkg::Depth];
  logic [spq_pkg::Depth-1:0]       gt_vec;
  logic [spq_pkg::Depth-1:0]       valid_vec;
  spq_pkg::cmd_t                   cmd;
  logic                            accept, full, empty, is_ins;
  logic [spq_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                            out_valid_q;
  spq_pkg::status_e                status_q, status_d;
  logic signed [spq_pkg::KeyW-1:0] okey_q, okey_d;
  logic signed [spq_pkg::ValW-1:0] oval_q, oval_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == spq_pkg::CntW'(spq_pkg::Depth));
  assign empty      = (cnt_q == '0);
  assign is_ins     = (req_type_i == spq_pkg::ReqInsert);

  assign cmd.ins   = accept && is_ins && !full;
  assign cmd.ext   = accept && !is_ins && !empty;
  assign cmd.key   = key_i;
  assign cmd.value = value_i;

  for (genvar i = 0; i < spq_pkg::Depth; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_gt;
    if (i == 0) begin : g_first
      assign left    = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left    = ent[i-1];
      assign left_gt = gt_vec[i-1];
    end
    if (i == spq_pkg::Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = ent[i+1];
    end
    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .ent_o     (ent[i]),
      .gt_o      (gt_vec[i])
    );
    assign valid_vec[i] = ent[i].valid;
  end

  always_comb begin
    cnt_d    = cnt_q;
    status_d = spq_pkg::StInserted;
    okey_d   = '0;
    oval_d   = '0;
    if (is_ins) begin
      if (full) begin
        status_d = spq_pkg::StFull;
      end else begin
        cnt_d = cnt_q + spq_pkg::CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::StEmpty;
      end else begin
        status_d = spq_pkg::StExtracted;
        okey_d   = ent[0].key;
        oval_d   = ent[0].value;
        cnt_d    = cnt_q - spq_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      oval_q   <= oval_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_key_o    = okey_q;
  assign out_value_o  = oval_q;
  assign fill_count_o = cnt_q;

  `ASSERT_PROP(a_cnt_matches_cells, $countones(valid_vec) == int'(cnt_q))
  `ASSERT_NEVER(a_cells_packed, ((valid_vec >> 1) & ~valid_vec) != '0)
  `ASSERT_PROP(a_ins_result, cmd.ins |=> out_valid_q && status_q == spq_pkg::StInserted)
  `ASSERT_PROP(a_ext_result, cmd.ext |=> out_valid_q && status_q == spq_pkg::StExtracted)

endmodule

`default_nettype wire
